[sv/assert_macros.svh]
// Assertion macros used by the top level of the septet packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on a given clock, disabled while the active-low reset is asserted.
`define B2S_ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("b2s assertion failed");

// Check a property on the module's clk_i and rst_ni.
`define B2S_ASSERT(name, prop) \
  `B2S_ASSERT_CLK(name, clk_i, rst_ni, prop)

`else

`define B2S_ASSERT_CLK(name, clk, rstn, prop)
`define B2S_ASSERT(name, prop)

`endif

`endif

[sv/b2s_pkg.sv]
// Types and constants of the byte to septet packer.
`timescale 1ns / 1ps
`default_nettype none

package b2s_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SEPTET_W  = 7;
  localparam int unsigned GROUP_IN  = 8;
  localparam int unsigned GROUP_OUT = 7;
  localparam int unsigned GROUP_W   = SEPTET_W * GROUP_IN;
  localparam int unsigned FILL_W    = $clog2(GROUP_IN);

  typedef logic [SEPTET_W-1:0] septet_t;
  typedef logic [GROUP_W-1:0]  group_t;
  typedef logic [FILL_W-1:0]   fill_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stream_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              group_end;
    logic              stream_end;
  } out_item_t;

  // Contents of one output chain cell.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } chain_cell_t;

endpackage

`default_nettype wire

[sv/b2s_septet_cell.sv]
// One septet slot of the group collector.
`timescale 1ns / 1ps
`default_nettype none

module b2s_septet_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire logic              write_i,
  input  wire b2s_pkg::septet_t  septet_i,
  output b2s_pkg::septet_t       septet_o
);

  b2s_pkg::septet_t septet_q, septet_d;

  // Clear wins: unused slots must read as zero padding.
  always_comb begin
    septet_d = septet_q;
    if (clear_i) begin
      septet_d = '0;
    end else if (write_i) begin
      septet_d = septet_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      septet_q <= '0;
    end else begin
      septet_q <= septet_d;
    end
  end

  assign septet_o = septet_q;

endmodule

`default_nettype wire

[sv/b2s_out_cell.sv]
// One byte cell of the output shift chain.
`timescale 1ns / 1ps
`default_nettype none

module b2s_out_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic                 shift_i,
  input  wire b2s_pkg::out_item_t   load_item_i,
  input  wire b2s_pkg::chain_cell_t next_i,
  output b2s_pkg::chain_cell_t      cell_o
);

  logic               valid_q, valid_d;
  b2s_pkg::out_item_t item_q, item_d;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load_i) begin
      valid_d = 1'b1;
      item_d  = load_item_i;
    end else if (shift_i) begin
      // take the neighbor's contents as the head moves on
      valid_d = next_i.valid;
      item_d  = next_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.item  = item_q;

endmodule

`default_nettype wire

[sv/byte_to_septet_packer.sv]
// Top level of the byte to septet packer.
//
// Keeps bits 7..1 of every input byte and packs each run of eight septets
// into seven bytes, first septet most significant; a byte flagged
// stream_last closes the group early, zero padding the missing septets.
// One byte is accepted per cycle while the input is not stalled. A finished
// group waits in a hand-off register and is loaded into a row of seven
// byte cells that shifts one byte toward the output per transfer. With an
// empty chain the group is loaded as soon as it sits in the hand-off
// register, so the closing byte passes the hand-off register and then the
// first chain cell before the first packed byte is presented. Input is
// stalled only while the hand-off register holds a group that the output
// chain cannot take in that cycle; a group can enter the hand-off register
// at the same edge as the previous one leaves it. With an unstalled output,
// a stream of full groups runs at one byte per cycle, while a stream that
// ends after k bytes of a group still yields seven bytes for that group.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module byte_to_septet_packer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire b2s_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output b2s_pkg::out_item_t      out_data_o
);

  localparam int unsigned SeptetW  = b2s_pkg::SEPTET_W;
  localparam int unsigned ByteW    = b2s_pkg::BYTE_W;
  localparam int unsigned GroupIn  = b2s_pkg::GROUP_IN;
  localparam int unsigned GroupOut = b2s_pkg::GROUP_OUT;
  localparam int unsigned GroupW   = b2s_pkg::GROUP_W;
  localparam int unsigned FillW    = b2s_pkg::FILL_W;

  logic             in_xfer, out_xfer;
  b2s_pkg::septet_t septet;
  logic             emit;

  b2s_pkg::fill_t   fill_q, fill_d;
  b2s_pkg::septet_t store [GroupOut];
  b2s_pkg::group_t  group;

  logic             pend_valid_q, pend_valid_d;
  b2s_pkg::group_t  pend_group_q;
  logic             pend_stream_q;

  b2s_pkg::chain_cell_t chain [GroupOut];
  logic [GroupOut-1:0]  chain_valid;
  logic                 can_load, chain_load;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign septet   = in_data_i.data_byte[ByteW-1 -: SeptetW];
  assign emit     = (fill_q == FillW'(GroupIn - 1)) || in_data_i.stream_last;

  // Collector: one cell per held septet, cleared whenever a group leaves.
  for (genvar g = 0; g < GroupOut; g++) begin : g_collect
    b2s_septet_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (in_xfer && emit),
      .write_i  (in_xfer && !emit && (fill_q == FillW'(g))),
      .septet_i (septet),
      .septet_o (store[g])
    );
  end

  // Slots past the fill point hold zeros, so only the current slot is patched.
  always_comb begin
    group = '0;
    for (int i = 0; i < GroupOut; i++) begin
      group[GroupW-1-SeptetW*i -: SeptetW] =
        (fill_q == FillW'(i)) ? septet : store[i];
    end
    group[SeptetW-1:0] = (fill_q == FillW'(GroupIn - 1)) ? septet : '0;
  end

  always_comb begin
    fill_d = fill_q;
    if (in_xfer) begin
      fill_d = emit ? '0 : fill_q + FillW'(1);
    end
  end

  // Hand-off register between collector and output chain.
  assign can_load   = !chain[0].valid || (out_xfer && !chain[1].valid);
  assign chain_load = pend_valid_q && can_load;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (in_xfer && emit) begin
      pend_valid_d = 1'b1;
    end else if (chain_load) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      pend_group_q  <= group;
      pend_stream_q <= in_data_i.stream_last;
    end
  end

  assign in_stall_o = pend_valid_q && !chain_load;

  // Output chain: cell 0 drives the port, each cell takes its neighbor's byte.
  for (genvar g = 0; g < GroupOut; g++) begin : g_chain
    b2s_pkg::out_item_t   load_item;
    b2s_pkg::chain_cell_t next_cell;

    assign load_item.packed_byte = pend_group_q[GroupW-1-ByteW*g -: ByteW];
    assign load_item.group_end   = 1'(g == GroupOut - 1);
    assign load_item.stream_end  = 1'(g == GroupOut - 1) && pend_stream_q;

    if (g == GroupOut - 1) begin : g_tail
      assign next_cell = '0;
    end else begin : g_body
      assign next_cell = chain[g+1];
    end

    b2s_out_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (chain_load),
      .shift_i     (out_xfer),
      .load_item_i (load_item),
      .next_i      (next_cell),
      .cell_o      (chain[g])
    );

    assign chain_valid[g] = chain[g].valid;
  end

  assign out_valid_o = chain[0].valid;
  assign out_data_o  = chain[0].item;

  // Valid cells stay packed toward the head.
  `B2S_ASSERT(a_chain_packed, ((chain_valid >> 1) & ~chain_valid) == '0)
  // A load fills every cell.
  `B2S_ASSERT(a_load_fills, chain_load |=> (&chain_valid))
  // A stream end restarts the collector.
  `B2S_ASSERT(a_stream_restart, in_xfer && in_data_i.stream_last |=> fill_q == '0)

endmodule

`default_nettype wire
